>>> sv/assert_macros.svh
// Assertion macros shared by the false position root finder RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

>>> sv/fpcr_pkg.sv
// Package for the false position cubic root finder: payload structs,
// controller states, command and status structs. Depends on nothing.
`timescale 1ns / 1ps
package fpcr_pkg;
  localparam int DW = 32;
  localparam int TOL_W = 31;
  localparam int ITER_W = 8;
  localparam int ST_W = 2;

  localparam logic [ST_W-1:0] ST_CONVERGED = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_CHANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_LIMIT     = 2'd2;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 31'd655;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd64;
  localparam logic CFG_TOL  = 1'b0;
  localparam logic CFG_ITER = 1'b1;

  typedef struct packed {
    logic signed [DW-1:0] lower_bound;
    logic signed [DW-1:0] upper_bound;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] root;
    logic [ITER_W-1:0]    iterations;
    logic [ST_W-1:0]      status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FLO, S_FHI, S_CHECK, S_LOOP, S_DEN, S_DIV, S_XR, S_FXR, S_UPD, S_DONE
  } state_e;

  // Polynomial unit operations, one product per step.
  typedef struct packed {
    logic load;      // capture input bounds
    logic poly_lo;   // start f at lower
    logic poly_hi;   // start f at upper
    logic init;      // compute err, last
    logic den;       // compute denominator and numerator
    logic div_start; // start muldiv
    logic xr;        // form secant point
    logic poly_xr;   // start f at xr
    logic update;    // replace bound, measure change
    logic done;      // present result
    logic [ST_W-1:0] status;
    logic inc_iter;
  } cmd_t;

  typedef struct packed {
    logic poly_busy;
    logic div_busy;
    logic no_change;
    logic err_gt_tol;
    logic iter_at_max;
    logic fxr_zero;
  } sts_t;
endpackage

>>> sv/fpcr_divider.sv
// Restoring divider: unsigned 128-by-64 bit, one quotient bit per cycle.
// Depends on nothing; magnitudes only, sign handled by the caller.
`timescale 1ns / 1ps
module fpcr_divider #(
  parameter int NW = 128,
  parameter int DWD = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DWD-1:0] den_i,
  output logic           busy_o,
  output logic [NW-1:0]  quot_o
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]  quot_q, quot_d;
  logic [DWD:0]   rem_q, rem_d;
  logic [DWD-1:0] den_q, den_d;
  logic [DWD:0]   shifted;

  always_comb begin
    cnt_d = cnt_q;
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    shifted = {rem_q[DWD-1:0], quot_q[NW-1]};
    if (start_i) begin
      cnt_d = CW'(NW);
      quot_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // shift numerator bits up through the quotient register
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

>>> sv/fpcr_datapath.sv
// Datapath of the root finder: bound registers, polynomial sequencer with
// one shared multiplier, divider instance. Depends on fpcr_pkg, fpcr_divider.
`timescale 1ns / 1ps
module fpcr_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpcr_pkg::cmd_t              cmd_i,
  input  logic signed [DATA_WIDTH-1:0] lo_in_i,
  input  logic signed [DATA_WIDTH-1:0] hi_in_i,
  input  logic [fpcr_pkg::TOL_W-1:0]  tol_i,
  input  logic [fpcr_pkg::ITER_W-1:0] max_iter_i,
  output fpcr_pkg::sts_t              sts_o,
  output logic signed [DATA_WIDTH-1:0] root_o,
  output logic [fpcr_pkg::ITER_W-1:0] iter_o
);
  localparam int W = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0] FIVE_W = (W+1)'(5) << FRAC_BITS;
  localparam logic signed [W-1:0] FIVE = (FIVE_W > {2'b0, VMAX[W-2:0]}) ? VMAX
                                         : FIVE_W[W-1:0];

  // Polynomial sequencer phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_MUL_XX   = 3'd1;
  localparam logic [2:0] PH_SAT_XX   = 3'd2;
  localparam logic [2:0] PH_MUL_CUBE = 3'd3;
  localparam logic [2:0] PH_SAT_CUBE = 3'd4;
  localparam logic [2:0] PH_COMBINE  = 3'd5;

  // Polynomial result targets.
  localparam logic [1:0] TGT_LO = 2'd0;
  localparam logic [1:0] TGT_HI = 2'd1;
  localparam logic [1:0] TGT_XR = 2'd2;

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // Saturating conversion from sign and wide magnitude.
  function automatic logic signed [W-1:0] from_mag(input logic neg,
                                                   input logic [PW-1:0] m);
    if (!neg) return (m > PW'(VMAX)) ? VMAX : m[W-1:0];
    if (m > PW'(VMAX)) return VMIN;
    return W'(~m + 1'b1);
  endfunction

  logic signed [W-1:0] lo_q, hi_q, flo_q, fhi_q, last_q, err_q, xr_q, fxr_q, den_q;
  logic [fpcr_pkg::ITER_W-1:0] iter_q;
  logic signed [W-1:0] d_w, den_w;

  logic [1:0] ptgt_q;
  logic signed [W-1:0] px_q, pa_q;
  logic neg_m_q;
  logic [PW-1:0] pm_q;
  logic signed [W-1:0] pmul_res;

  assign d_w = ssub(hi_q, lo_q);
  assign den_w = ssub(fhi_q, flo_q);

  logic [PW-1:0] prod_mag;
  assign prod_mag = PW'(mag(px_q)) * PW'(mag(pa_q));

  always_comb begin
    pmul_res = from_mag(neg_m_q, pm_q >> FRAC_BITS);
  end

  // Stage after the multiplier keeps the next product off the same path.
  logic [2:0] pph_q;

  logic signed [W-1:0] cube2, fres;
  always_comb begin
    cube2 = sadd(pa_q, pa_q);
    fres = ssub(ssub(cube2, sadd(px_q, px_q)), FIVE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pph_q <= PH_IDLE;
    end else begin
      case (pph_q)
        PH_IDLE: if (cmd_i.poly_lo || cmd_i.poly_hi || cmd_i.poly_xr) pph_q <= PH_MUL_XX;
        PH_COMBINE: pph_q <= PH_IDLE;
        default: pph_q <= pph_q + 3'd1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pph_q == PH_IDLE) begin
      if (cmd_i.poly_lo) begin
        px_q <= lo_q; pa_q <= lo_q; ptgt_q <= TGT_LO;
      end else if (cmd_i.poly_hi) begin
        px_q <= hi_q; pa_q <= hi_q; ptgt_q <= TGT_HI;
      end else if (cmd_i.poly_xr) begin
        px_q <= xr_q; pa_q <= xr_q; ptgt_q <= TGT_XR;
      end
    end
    if (pph_q == PH_MUL_XX || pph_q == PH_MUL_CUBE) begin
      pm_q <= prod_mag;
      neg_m_q <= px_q[W-1] ^ pa_q[W-1];
    end
    if (pph_q == PH_SAT_XX || pph_q == PH_SAT_CUBE) pa_q <= pmul_res;
  end

  // Muldiv: |fhi|*|d| exact, divided by |den|.
  logic div_busy;
  logic [PW-1:0] quot;
  logic div_neg_q;
  logic [PW-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.den) num_q <= PW'(mag(fhi_q)) * PW'(mag(d_w));
  end

  fpcr_divider #(.NW(PW), .DWD(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (mag(den_q)),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  logic signed [W-1:0] q_sat;
  assign q_sat = from_mag(div_neg_q, quot);

  logic pending_q;
  logic signed [W-1:0] d_err;
  assign d_err = mag(ssub(last_q, xr_q)) > W'(VMAX) ? VMAX : mag(ssub(last_q, xr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= (pph_q == PH_COMBINE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q <= lo_in_i;
      hi_q <= hi_in_i;
      iter_q <= '0;
    end
    if (pph_q == PH_COMBINE) begin
      case (ptgt_q)
        TGT_LO: flo_q <= fres;
        TGT_HI: fhi_q <= fres;
        default: fxr_q <= fres;
      endcase
    end
    if (cmd_i.init) begin
      err_q <= (mag(d_w) > W'(VMAX)) ? VMAX : mag(d_w);
      last_q <= hi_q;
    end
    if (cmd_i.inc_iter) iter_q <= iter_q + 1'b1;
    if (cmd_i.den) begin
      den_q <= den_w;
      div_neg_q <= fhi_q[W-1] ^ d_w[W-1] ^ den_w[W-1];
    end
    if (cmd_i.xr) xr_q <= (den_q == '0) ? hi_q : ssub(hi_q, q_sat);
    if (cmd_i.update) begin
      if (fxr_q == '0) begin
        last_q <= xr_q;
      end else begin
        if (flo_q[W-1] != fxr_q[W-1]) begin
          hi_q <= xr_q; fhi_q <= fxr_q;
        end else begin
          lo_q <= xr_q; flo_q <= fxr_q;
        end
        err_q <= d_err;
        last_q <= xr_q;
      end
    end
  end

  assign sts_o.poly_busy  = (pph_q != PH_IDLE) || pending_q;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.no_change  = (flo_q == '0) || (fhi_q == '0) || (flo_q[W-1] == fhi_q[W-1]);
  assign sts_o.err_gt_tol = $unsigned(err_q) > W'(tol_i);
  assign sts_o.iter_at_max = iter_q >= max_iter_i;
  assign sts_o.fxr_zero   = (fxr_q == '0);
  assign root_o = last_q;
  assign iter_o = iter_q;
endmodule

>>> sv/fpcr_ctrl.sv
// Controller of the root finder: sequences evaluation, division and update.
// Depends on fpcr_pkg.
`timescale 1ns / 1ps
module fpcr_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  fpcr_pkg::sts_t          sts_i,
  output fpcr_pkg::cmd_t          cmd_o,
  output logic                    busy_o
);
  fpcr_pkg::state_e state_q, state_d;
  logic [fpcr_pkg::ST_W-1:0] st_q, st_d;
  logic wait_q, wait_d; // masks busy until a started unit reports it

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    wait_d = 1'b0;
    case (state_q)
      fpcr_pkg::S_IDLE: if (start_i) state_d = fpcr_pkg::S_FLO;
      fpcr_pkg::S_FLO: begin
        state_d = fpcr_pkg::S_FHI;
        wait_d = 1'b1;
      end
      fpcr_pkg::S_FHI: if (!wait_q && !sts_i.poly_busy) begin
        state_d = fpcr_pkg::S_CHECK;
        wait_d = 1'b1;
      end
      fpcr_pkg::S_CHECK: if (!wait_q && !sts_i.poly_busy) begin
        if (sts_i.no_change) begin
          st_d = fpcr_pkg::ST_NO_CHANGE;
          state_d = fpcr_pkg::S_DONE;
        end else begin
          state_d = fpcr_pkg::S_LOOP;
        end
      end
      fpcr_pkg::S_LOOP: begin
        if (!sts_i.err_gt_tol) begin
          st_d = fpcr_pkg::ST_CONVERGED;
          state_d = fpcr_pkg::S_DONE;
        end else if (sts_i.iter_at_max) begin
          st_d = fpcr_pkg::ST_LIMIT;
          state_d = fpcr_pkg::S_DONE;
        end else begin
          state_d = fpcr_pkg::S_DEN;
        end
      end
      fpcr_pkg::S_DEN: begin
        state_d = fpcr_pkg::S_DIV;
        wait_d = 1'b1;
      end
      fpcr_pkg::S_DIV: if (!wait_q && !sts_i.div_busy) state_d = fpcr_pkg::S_XR;
      fpcr_pkg::S_XR: begin
        state_d = fpcr_pkg::S_FXR;
        wait_d = 1'b1;
      end
      fpcr_pkg::S_FXR: if (!wait_q && !sts_i.poly_busy) state_d = fpcr_pkg::S_UPD;
      fpcr_pkg::S_UPD: begin
        if (sts_i.fxr_zero) begin
          st_d = fpcr_pkg::ST_CONVERGED;
          state_d = fpcr_pkg::S_DONE;
        end else begin
          state_d = fpcr_pkg::S_LOOP;
        end
      end
      fpcr_pkg::S_DONE: state_d = fpcr_pkg::S_IDLE;
      default: state_d = fpcr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = st_q;
    case (state_q)
      fpcr_pkg::S_IDLE: cmd_o.load = start_i;
      fpcr_pkg::S_FLO: cmd_o.poly_lo = 1'b1;
      fpcr_pkg::S_FHI: cmd_o.poly_hi = !wait_q && !sts_i.poly_busy;
      fpcr_pkg::S_CHECK: cmd_o.init = !wait_q && !sts_i.poly_busy;
      fpcr_pkg::S_LOOP: cmd_o.inc_iter = sts_i.err_gt_tol && !sts_i.iter_at_max;
      fpcr_pkg::S_DEN: cmd_o.den = 1'b1;
      fpcr_pkg::S_DIV: cmd_o.div_start = wait_q;
      fpcr_pkg::S_XR: cmd_o.xr = 1'b1;
      fpcr_pkg::S_FXR: cmd_o.poly_xr = wait_q;
      fpcr_pkg::S_UPD: cmd_o.update = 1'b1;
      fpcr_pkg::S_DONE: cmd_o.done = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpcr_pkg::S_IDLE;
      st_q <= fpcr_pkg::ST_CONVERGED;
      wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      wait_q <= wait_d;
    end
  end

  assign busy_o = (state_q != fpcr_pkg::S_IDLE);
endmodule

>>> sv/false_position_cubic_root_core.sv
// Top level of the false position root finder for f(x) = 2x^3 - 2x - 5.
// Depends on fpcr_pkg, fpcr_ctrl, fpcr_datapath, fpcr_divider, assert_macros.svh.
//
// Usage:
//   Input: a transaction is taken at a clock edge with start high and
//   busy low; in_i carries lower_bound and upper_bound (signed Q16.16).
//   Output: done_o pulses for one cycle with out_o carrying root, iterations
//   and status. The receiver cannot stall; take the result in that cycle.
//   Configuration: cfg_we_i with cfg_idx_i 0 writes tolerance, 1 writes
//   max_iterations; write only while busy is low.
// Sequencing:
//   One transaction at a time. Each f evaluation holds the shared multiplier
//   sequencer; each secant step includes the restoring division (64 quotient
//   bits, one per cycle). The run ends after the check with no sign change,
//   and in the update step when f is exactly zero at the secant point.
//   The next transaction can be taken in the cycle after the result.
// Reset:
//   Reset returns the controller to idle and loads tolerance 655 and
//   max_iterations 64. No result is pending after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module false_position_cubic_root_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  fpcr_pkg::in_t       in_i,
  output logic                done_o,
  output fpcr_pkg::out_t      out_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [fpcr_pkg::TOL_W-1:0] cfg_data_i
);
  fpcr_pkg::cmd_t cmd;
  fpcr_pkg::sts_t sts;
  logic [fpcr_pkg::TOL_W-1:0]  tol_q;
  logic [fpcr_pkg::ITER_W-1:0] max_iter_q;
  logic signed [fpcr_pkg::DW-1:0] root;
  logic [fpcr_pkg::ITER_W-1:0] iter;

  // Hold configuration registers; write only at the addressed index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= fpcr_pkg::TOL_RESET;
      max_iter_q <= fpcr_pkg::ITER_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fpcr_pkg::CFG_TOL) tol_q <= cfg_data_i;
      else max_iter_q <= cfg_data_i[fpcr_pkg::ITER_W-1:0];
    end
  end

  fpcr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  fpcr_datapath #(.DATA_WIDTH(fpcr_pkg::DW), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .lo_in_i    (in_i.lower_bound),
    .hi_in_i    (in_i.upper_bound),
    .tol_i      (tol_q),
    .max_iter_i (max_iter_q),
    .sts_o      (sts),
    .root_o     (root),
    .iter_o     (iter)
  );

  // Drop the estimate and zero the count on no sign change; else report both as computed.
  assign done_o = cmd.done;
  assign out_o.root = (cmd.status == fpcr_pkg::ST_NO_CHANGE) ? '0 : root;
  assign out_o.iterations = (cmd.status == fpcr_pkg::ST_NO_CHANGE) ? '0 : iter;
  assign out_o.status = cmd.status;

  `ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy, "result outside a transaction")
  `ASSERT_IMPL(a_iter_lim, clk_i, rst_ni, done_o, out_o.iterations <= max_iter_q, "over limit")
  `ASSERT_ALWAYS(a_status_ok, clk_i, rst_ni, !done_o || out_o.status != 2'd3, "bad status")
endmodule
